// File: rtl/hcbd_pkg.sv
// Package for the HTTP chunked body decoder.
// Holds the decoder phase type, character constants, the hex digit decoder
// and the control struct passed from the step logic to the top level.
package hcbd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned CNT_W   = 23;
    localparam int unsigned DIGIT_W = 4;

    localparam logic [CNT_W-1:0]  OUT_LIMIT_RESET = CNT_W'(4194304);
    localparam logic [BYTE_W-1:0] CHAR_LF         = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR         = 8'h0D;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SKIP,
        PH_DATA,
        PH_TRAIL,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic is_hex;
        logic [DIGIT_W-1:0] value;
    } hex_digit_t;

    typedef struct packed {
        logic emit;
        logic data_valid;
        logic finished;
    } step_ctrl_t;

    function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] b);
        hex_digit_t h;
        h.is_hex = 1'b0;
        h.value  = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.is_hex = 1'b1;
            h.value  = DIGIT_W'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.is_hex = 1'b1;
            h.value  = DIGIT_W'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.is_hex = 1'b1;
            h.value  = DIGIT_W'(b - 8'h37);
        end
        return h;
    endfunction

endpackage

// File: rtl/hcbd_step.sv
// Per-byte step logic of the HTTP chunked body decoder.
// Computes the next phase, chunk countdown and output count for one byte.
// Depends on hcbd_pkg.
module hcbd_step (
    input  hcbd_pkg::phase_t                      phase,
    input  logic [hcbd_pkg::SIZE_W-1:0]           chunk_remaining,
    input  logic [hcbd_pkg::CNT_W-1:0]            out_count,
    input  logic [hcbd_pkg::CNT_W-1:0]            out_limit,
    input  logic [hcbd_pkg::BYTE_W-1:0]           raw_byte,
    input  logic                                  last_byte,
    output hcbd_pkg::phase_t                      phase_next,
    output logic [hcbd_pkg::SIZE_W-1:0]           chunk_remaining_next,
    output logic [hcbd_pkg::CNT_W-1:0]            out_count_next,
    output logic [hcbd_pkg::CNT_W-1:0]            total_length,
    output hcbd_pkg::step_ctrl_t                  ctrl
);
    import hcbd_pkg::*;

    hex_digit_t         digit;
    phase_t             eff_phase;
    logic               is_crlf;
    logic               done;
    logic               valid;
    logic               fin;
    logic [SIZE_W-1:0]  chunk_dec;
    logic [CNT_W-1:0]   count_upd;

    assign digit     = hex_decode(raw_byte);
    assign is_crlf   = (raw_byte == CHAR_CR) || (raw_byte == CHAR_LF);
    assign done      = (phase == PH_DONE);
    assign chunk_dec = chunk_remaining - SIZE_W'(1);

    always_comb begin
        if (phase == PH_TRAIL && !is_crlf) begin
            eff_phase = PH_SIZE;
        end else begin
            eff_phase = phase;
        end
        phase_next           = eff_phase;
        chunk_remaining_next = chunk_remaining;
        count_upd            = out_count;
        valid                = 1'b0;
        fin                  = 1'b0;

        case (eff_phase)
            PH_SIZE: begin
                if (digit.is_hex) begin
                    chunk_remaining_next = {chunk_remaining[SIZE_W-DIGIT_W-1:0], digit.value};
                end else if (raw_byte == CHAR_LF) begin
                    if (chunk_remaining == '0) begin
                        fin = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (raw_byte == CHAR_LF) begin
                    if (chunk_remaining == '0) begin
                        fin = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (out_count < out_limit) begin
                    valid     = 1'b1;
                    count_upd = out_count + CNT_W'(1);
                end
                chunk_remaining_next = chunk_dec;
                if (chunk_dec == '0) begin
                    if (count_upd >= out_limit) begin
                        fin = 1'b1;
                    end else begin
                        phase_next = PH_TRAIL;
                    end
                end
            end
            default: begin
            end
        endcase

        out_count_next = count_upd;
        if (done) begin
            valid = 1'b0;
            fin   = 1'b0;
        end else begin
            if (last_byte) begin
                fin = 1'b1;
            end
            if (fin) begin
                phase_next = PH_DONE;
            end
        end
        if (last_byte) begin
            phase_next           = PH_SIZE;
            chunk_remaining_next = '0;
            out_count_next       = '0;
        end
    end

    assign total_length    = count_upd;
    assign ctrl.emit       = valid || fin;
    assign ctrl.data_valid = valid;
    assign ctrl.finished   = fin;

endmodule

// File: rtl/http_chunked_body_decoder_core.sv
// Top level of the HTTP chunked body decoder: state registers, limit
// register and result register. Depends on hcbd_pkg and hcbd_step.
//
//  Channel  | Ports                                            | Direction
//  ---------+--------------------------------------------------+----------
//  input    | s_valid, s_ready, s_raw_byte, s_last_byte        | in
//  result   | m_valid, m_ready, m_data_byte, m_data_valid,     | out
//           | m_finished, m_total_length                       |
//  config   | cfg_wr_en, cfg_wr_data                           | in
//
// Each byte request is decoded combinationally from the phase, chunk countdown
// and output count registers into a single result register, so a new
// request is taken every cycle while results drain. The input stalls only
// while a result is held and m_ready is low. Reset is synchronous and
// returns the decoder to the size phase with the limit at its reset value.
module http_chunked_body_decoder_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [hcbd_pkg::BYTE_W-1:0]       s_raw_byte,
    input  logic                              s_last_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hcbd_pkg::BYTE_W-1:0]       m_data_byte,
    output logic                              m_data_valid,
    output logic                              m_finished,
    output logic [hcbd_pkg::CNT_W-1:0]        m_total_length,
    input  logic                              cfg_wr_en,
    input  logic [hcbd_pkg::CNT_W-1:0]        cfg_wr_data
);
    import hcbd_pkg::*;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [SIZE_W-1:0]   chunk_reg;
    logic [SIZE_W-1:0]   chunk_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    limit_reg;
    logic [CNT_W-1:0]    total_next;
    step_ctrl_t          ctrl;

    logic                m_valid_reg;
    logic [BYTE_W-1:0]   m_data_byte_reg;
    logic                m_data_valid_reg;
    logic                m_finished_reg;
    logic [CNT_W-1:0]    m_total_length_reg;
    logic                accept;

    hcbd_step u_step (
        .phase                (phase_reg),
        .chunk_remaining      (chunk_reg),
        .out_count            (count_reg),
        .out_limit            (limit_reg),
        .raw_byte             (s_raw_byte),
        .last_byte            (s_last_byte),
        .phase_next           (phase_next),
        .chunk_remaining_next (chunk_next),
        .out_count_next       (count_next),
        .total_length         (total_next),
        .ctrl                 (ctrl)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIZE;
            chunk_reg <= '0;
            count_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            chunk_reg <= chunk_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= OUT_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && ctrl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && ctrl.emit) begin
            m_data_byte_reg    <= ctrl.data_valid ? s_raw_byte : '0;
            m_data_valid_reg   <= ctrl.data_valid;
            m_finished_reg     <= ctrl.finished;
            m_total_length_reg <= total_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data_byte    = m_data_byte_reg;
    assign m_data_valid   = m_data_valid_reg;
    assign m_finished     = m_finished_reg;
    assign m_total_length = m_total_length_reg;

`ifndef ASSERT_OFF
    a_result_has_content: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data_valid || m_finished))
        else $error("Result without data or finish flag.");

    a_no_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data_valid) |-> (m_data_byte == '0))
        else $error("Result without data carries a nonzero byte.");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_byte) |=>
            (phase_reg == PH_SIZE && chunk_reg == '0 && count_reg == '0))
        else $error("Decoder did not restart after the last byte.");
`endif

endmodule
